/* hw/rtl/vts_pkg.sv */
// ----------------------------------------------------------------------------
// vts_pkg
// Shared types and constants of the trilinear volume sampler: mode and
// register codes, controller states and the controller/datapath buses.
// ----------------------------------------------------------------------------
package vts_pkg;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	localparam logic [1:0] REG_VOL_WIDTH  = 2'd0;
	localparam logic [1:0] REG_VOL_HEIGHT = 2'd1;
	localparam logic [1:0] REG_VOL_SLICES = 2'd2;

	localparam logic [6:0] DIM_RESET   = 7'd64;
	localparam logic [2:0] CORNER_LAST = 3'd7;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CALC,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic       wr;
		logic       load;
		logic       calc;
		logic       rd_en;
		logic [2:0] corner;
		logic       finish;
	} cmd_t;

	typedef struct packed {
		logic ok;
		logic busy;
		logic out_free;
	} status_t;

endpackage

/* hw/rtl/vts_ctrl.sv */
// ----------------------------------------------------------------------------
// vts_ctrl
// Sequencer: accepts items, walks the eight corner reads of a sample and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module vts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              mode,
	input  vts_pkg::status_t  status,
	output vts_pkg::cmd_t     cmd
);

	vts_pkg::state_t state_q, state_d;
	logic [2:0]      cnt_q;
	logic            accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vts_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == vts_pkg::ST_READ) begin
				cnt_q <= cnt_q + 3'd1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = (state_q == vts_pkg::ST_IDLE);
		accept     = in_valid && in_ready;
		cmd.wr     = accept && (mode == vts_pkg::MODE_WRITE);
		cmd.load   = accept && (mode == vts_pkg::MODE_SAMPLE);
		cmd.calc   = (state_q == vts_pkg::ST_CALC);
		cmd.rd_en  = (state_q == vts_pkg::ST_READ);
		cmd.corner = cnt_q;
		cmd.finish = (state_q == vts_pkg::ST_FINISH) && status.out_free;
		unique case (state_q)
			vts_pkg::ST_IDLE: begin
				if (cmd.load) state_d = vts_pkg::ST_CALC;
			end
			vts_pkg::ST_CALC: begin
				state_d = status.ok ? vts_pkg::ST_READ : vts_pkg::ST_FINISH;
			end
			vts_pkg::ST_READ: begin
				if (cnt_q == vts_pkg::CORNER_LAST) state_d = vts_pkg::ST_DRAIN;
			end
			vts_pkg::ST_DRAIN: begin
				if (!status.busy) state_d = vts_pkg::ST_FINISH;
			end
			vts_pkg::ST_FINISH: begin
				if (status.out_free) state_d = vts_pkg::ST_IDLE;
			end
			default: begin
				state_d = vts_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/vts_datapath.sv */
// ----------------------------------------------------------------------------
// vts_datapath
// Voxel memory, configuration registers, corner addressing, weight
// multipliers, accumulator and output register.
// ----------------------------------------------------------------------------
module vts_datapath #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_SLICES = 64,
	parameter int FRAC_BITS  = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vts_pkg::cmd_t       cmd,
	output vts_pkg::status_t    status,
	input  logic [5:0]          write_x,
	input  logic [5:0]          write_y,
	input  logic [5:0]          write_z,
	input  logic [15:0]         write_value,
	input  logic signed [15:0]  point_x,
	input  logic signed [15:0]  point_y,
	input  logic signed [15:0]  point_z,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [6:0]          cfg_data,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [15:0]         sample,
	output logic                in_range
);

	localparam int DEPTH = MAX_SLICES * MAX_HEIGHT * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int ROW   = MAX_WIDTH;
	localparam int PLANE = MAX_WIDTH * MAX_HEIGHT;
	localparam int S     = 1 << FRAC_BITS;
	localparam int WW    = FRAC_BITS + 1;
	localparam int PW    = 16 + WW;
	localparam int YZW   = 2 * WW;
	localparam int QW    = PW + YZW;
	localparam int ACCW  = 16 + 3 * FRAC_BITS;

	logic [15:0]           mem [DEPTH];

	logic [6:0]            vol_width_q, vol_height_q, vol_slices_q;

	logic                  wr_inside;
	logic                  wr_s1;
	logic [AW-1:0]         wr_addr_s1;
	logic [15:0]           wr_data_s1;

	logic signed [15:0]    px_q, py_q, pz_q;
	logic                  neg;
	logic [15:0]           x0, y0, z0;
	logic [FRAC_BITS-1:0]  fx, fy, fz;
	logic [10:0]           eff_w, eff_h, eff_d;
	logic                  ok;
	logic [WW-1:0]         wy_c [2];
	logic [WW-1:0]         wz_c [2];

	logic                  ok_q;
	logic [AW-1:0]         base_q;
	logic [WW-1:0]         wx_q [2];
	logic [YZW-1:0]        wyz_q [4];

	logic [AW-1:0]         rd_addr;
	logic                  v_s1, v_s2, v_s3;
	logic [15:0]           rdata_s1;
	logic [2:0]            corner_s1;
	logic [PW-1:0]         p_s2;
	logic [1:0]            cyz_s2;
	logic [QW-1:0]         q_s3;
	logic [ACCW-1:0]       acc_q;

	logic                  out_valid_q;
	logic [15:0]           sample_q;
	logic                  in_range_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_width_q  <= vts_pkg::DIM_RESET;
			vol_height_q <= vts_pkg::DIM_RESET;
			vol_slices_q <= vts_pkg::DIM_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				vts_pkg::REG_VOL_WIDTH:  vol_width_q  <= cfg_data;
				vts_pkg::REG_VOL_HEIGHT: vol_height_q <= cfg_data;
				vts_pkg::REG_VOL_SLICES: vol_slices_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign wr_inside = (11'(write_x) < 11'(MAX_WIDTH)) && (11'(write_y) < 11'(MAX_HEIGHT))
		&& (11'(write_z) < 11'(MAX_SLICES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_s1 <= 1'b0;
		end else begin
			wr_s1 <= cmd.wr && wr_inside;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			wr_addr_s1 <= AW'((32'(write_z) * MAX_HEIGHT + 32'(write_y)) * MAX_WIDTH
				+ 32'(write_x));
			wr_data_s1 <= write_value;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_s1) begin
			mem[wr_addr_s1] <= wr_data_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= point_x;
			py_q <= point_y;
			pz_q <= point_z;
		end
	end

	always_comb begin
		neg   = px_q[15] || py_q[15] || pz_q[15];
		x0    = px_q >> FRAC_BITS;
		y0    = py_q >> FRAC_BITS;
		z0    = pz_q >> FRAC_BITS;
		fx    = px_q[FRAC_BITS-1:0];
		fy    = py_q[FRAC_BITS-1:0];
		fz    = pz_q[FRAC_BITS-1:0];
		eff_w = (11'(vol_width_q) < 11'(MAX_WIDTH)) ? 11'(vol_width_q) : 11'(MAX_WIDTH);
		eff_h = (11'(vol_height_q) < 11'(MAX_HEIGHT)) ? 11'(vol_height_q) : 11'(MAX_HEIGHT);
		eff_d = (11'(vol_slices_q) < 11'(MAX_SLICES)) ? 11'(vol_slices_q) : 11'(MAX_SLICES);
		ok    = !neg
			&& ((17'(x0) + 17'd1) < 17'(eff_w))
			&& ((17'(y0) + 17'd1) < 17'(eff_h))
			&& ((17'(z0) + 17'd1) < 17'(eff_d));
		wy_c[0] = WW'(S) - WW'(fy);
		wy_c[1] = WW'(fy);
		wz_c[0] = WW'(S) - WW'(fz);
		wz_c[1] = WW'(fz);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			ok_q     <= ok;
			base_q   <= AW'((32'(z0) * MAX_HEIGHT + 32'(y0)) * MAX_WIDTH + 32'(x0));
			wx_q[0]  <= WW'(S) - WW'(fx);
			wx_q[1]  <= WW'(fx);
			for (int i = 0; i < 4; i++) begin
				wyz_q[i] <= YZW'(wy_c[i[0]]) * YZW'(wz_c[i[1]]);
			end
		end
	end

	assign rd_addr = base_q
		+ (cmd.corner[0] ? AW'(1) : AW'(0))
		+ (cmd.corner[1] ? AW'(ROW) : AW'(0))
		+ (cmd.corner[2] ? AW'(PLANE) : AW'(0));

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_s1  <= mem[rd_addr];
			corner_s1 <= cmd.corner;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= cmd.rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		p_s2   <= PW'(rdata_s1) * PW'(wx_q[corner_s1[0]]);
		cyz_s2 <= corner_s1[2:1];
		q_s3   <= QW'(p_s2) * QW'(wyz_q[cyz_s2]);
		if (cmd.calc) begin
			acc_q <= '0;
		end else if (v_s3) begin
			acc_q <= acc_q + ACCW'(q_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			sample_q   <= ok_q ? acc_q[3*FRAC_BITS +: 16] : 16'd0;
			in_range_q <= ok_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign sample          = sample_q;
	assign in_range        = in_range_q;
	assign status.ok       = ok;
	assign status.busy     = v_s1 || v_s2 || v_s3;
	assign status.out_free = !out_valid_q || out_ready;

	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !wr_s1)
		else $error("voxel read and write in the same cycle");

	a_finish_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(v_s1 || v_s2 || v_s3))
		else $error("result taken before the corner pipeline drained");

	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !in_range_q) |-> (sample_q == 16'd0))
		else $error("out-of-range result carries a nonzero sample");

	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc |=> (acc_q == '0))
		else $error("accumulator not cleared at start of sample");

endmodule

/* hw/rtl/volume_trilinear_sampler_top.sv */
// ----------------------------------------------------------------------------
// volume_trilinear_sampler_top
// Trilinear sampler over a stored volume of 16-bit voxels.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    mode, write_*, point_*
//   out      output     out_valid / out_ready  sample, in_range
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A write item is taken while the controller stays idle; the voxel lands in
// memory the cycle after. A sample in range passes a setup state, eight corner
// reads through the single memory read port, a drain state that waits for the
// corner pipeline and an output state; one out of range skips read and drain.
// Reset clears control state and loads the size registers; the voxel memory
// is left as is. cfg is always ready. A new item is taken while a result
// waits in the output register; the next result holds until it is taken.
// ----------------------------------------------------------------------------
module volume_trilinear_sampler_top #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_SLICES = 64,
	parameter int FRAC_BITS  = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic [5:0]         write_x,
	input  logic [5:0]         write_y,
	input  logic [5:0]         write_z,
	input  logic [15:0]        write_value,
	input  logic signed [15:0] point_x,
	input  logic signed [15:0] point_y,
	input  logic signed [15:0] point_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [15:0]        sample,
	output logic               in_range,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);

	vts_pkg::cmd_t    cmd;
	vts_pkg::status_t status;

	vts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.status   (status),
		.cmd      (cmd)
	);

	vts_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_SLICES (MAX_SLICES),
		.FRAC_BITS  (FRAC_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.write_x     (write_x),
		.write_y     (write_y),
		.write_z     (write_z),
		.write_value (write_value),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_z     (point_z),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.sample      (sample),
		.in_range    (in_range)
	);

endmodule
